/* hdl/cep_pkg.sv */
package cep_pkg;

    // Fixed field widths
    localparam int SET_SIZE_W = 11;
    localparam int CHOOSE_W   = 4;
    localparam int REQ_W      = 2;
    localparam int PREFIX_W   = 4;
    localparam int POS_W      = 3;
    localparam int ELEM_W     = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Register reset values
    localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST     = 11'd8;
    localparam logic [CHOOSE_W-1:0]   CHOOSE_COUNT_RST = 4'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_RESTART = 2'd0,
        REQ_NEXT    = 2'd1,
        REQ_SKIP    = 2'd2
    } req_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_SIZE     = 1'b0,
        CFG_CHOOSE_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [PREFIX_W-1:0] prefix_length;
    } req_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element_index;
        logic              done_res;
        logic              last;
    } res_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic restart;
        logic fin_set;
        logic scan_start;
        logic ptr_clear;
        logic ptr_dec;
        logic ptr_inc;
        logic bump;
        logic emit;
    } cep_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_restart;
        logic is_next;
        logic is_skip;
        logic k_gt_n;
        logic finished;
        logic prefix_zero;
        logic can_rise;
        logic ptr_zero;
        logic ptr_last;
        logic out_free;
    } cep_status_t;

endpackage

/* hdl/combination_enumerator_with_skip.sv */
// Lexicographic k-combination enumerator with prefix skip. Holds an ascending
// k-combination of indices from 0..N-1 (N = set_size, k = choose_count, both
// clamped to 1..MAX_SET_SIZE and 1..MAX_CHOOSE). Each request transaction
// (restart, next, skip prefix p) updates the combination and then produces k
// result transactions, positions 0..k-1 in order, the final one flagged last;
// done_res reports that the enumeration is exhausted. One request is handled
// at a time: it is accepted, then decoded, then where needed for next/skip a
// scan of one position per cycle over the single read port of the index
// register file (at most k positions for next, at most p for skip), then the
// k results are emitted one per cycle, unless the receiver stalls, through the
// output register. The last result may still be waiting in the output register
// while the next request is accepted. Configuration must be written only while
// no request is in flight; the block itself does not enforce this.
module combination_enumerator_with_skip
    import cep_pkg::*;
#(
    parameter int MAX_CHOOSE   = 8,
    parameter int MAX_SET_SIZE = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_item_t             req,
    // result channel
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_item_t             res
);

    cep_cmd_t    cmd;
    cep_status_t status;

    // Sequencer: accept, decode, scan, emit
    cep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Index register file, scan pointer, config and output register
    cep_dp #(
        .MAX_CHOOSE   (MAX_CHOOSE),
        .MAX_SET_SIZE (MAX_SET_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cmd       (cmd),
        .status    (status)
    );

    // At most one update of the combination or done flag per cycle
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.restart, cmd.fin_set, cmd.bump, cmd.scan_start}))
        else $error("conflicting datapath updates");

    // An accepted request keeps the request side stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request side not stalled after accept");

    // Loading the last result frees the request side on the next cycle
    a_free_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.ptr_last) |=> !req_stall)
        else $error("request side still stalled after last result");

    // A loaded result marked last sits at position k-1 and nothing more is emitted
    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.ptr_last) |=> !cmd.emit)
        else $error("result emitted after last");

endmodule

/* hdl/cep_ctrl.sv */
module cep_ctrl
    import cep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  cep_status_t status,
    output cep_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.is_restart)
                begin
                    cmd.restart   = 1'b1;
                    cmd.ptr_clear = 1'b1;
                    state_next    = ST_EMIT;
                end
                else if (status.is_next || status.is_skip)
                begin
                    if (status.k_gt_n || (status.is_skip && status.prefix_zero
                                          && !status.finished))
                    begin
                        cmd.fin_set   = 1'b1;
                        cmd.ptr_clear = 1'b1;
                        state_next    = ST_EMIT;
                    end
                    else if (status.finished)
                    begin
                        cmd.ptr_clear = 1'b1;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
                else
                begin
                    cmd.ptr_clear = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (status.can_rise)
                begin
                    cmd.bump      = 1'b1;
                    cmd.ptr_clear = 1'b1;
                    state_next    = ST_EMIT;
                end
                else if (status.ptr_zero)
                begin
                    cmd.fin_set   = 1'b1;
                    cmd.ptr_clear = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cmd.ptr_dec = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.ptr_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.ptr_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/cep_dp.sv */
module cep_dp
    import cep_pkg::*;
#(
    parameter int MAX_CHOOSE   = 8,
    parameter int MAX_SET_SIZE = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  req_item_t             req,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_item_t             res,
    input  cep_cmd_t              cmd,
    output cep_status_t           status
);

    // Largest usable set size given the register width
    localparam int SET_SIZE_MAX = (1 << SET_SIZE_W) - 1;
    localparam int EFF_MAX = (MAX_SET_SIZE > SET_SIZE_MAX) ? SET_SIZE_MAX : MAX_SET_SIZE;
    localparam int CHOOSE_MAX = (1 << CHOOSE_W) - 1;
    localparam int K_CAP = (MAX_CHOOSE > CHOOSE_MAX) ? CHOOSE_MAX : MAX_CHOOSE;
    localparam int IDX_TOP = (EFF_MAX > MAX_CHOOSE) ? EFF_MAX - 1 : MAX_CHOOSE - 1;
    localparam int IDX_W = (IDX_TOP < 2) ? 1 : $clog2(IDX_TOP + 1);
    localparam int PTR_W = (MAX_CHOOSE < 2) ? 1 : $clog2(MAX_CHOOSE);
    localparam int LIM_W = SET_SIZE_W + 1;
    localparam int CW = ((PTR_W > CHOOSE_W) ? PTR_W : CHOOSE_W) + 1;

    logic [SET_SIZE_W-1:0] set_size_reg;
    logic [CHOOSE_W-1:0]   choose_count_reg;

    logic [IDX_W-1:0] idx_reg  [MAX_CHOOSE];
    logic [IDX_W-1:0] idx_next [MAX_CHOOSE];
    logic             finished_reg;
    logic             finished_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [REQ_W-1:0] req_reg;
    logic [CHOOSE_W-1:0] p_eff_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    res_item_t        res_reg;
    res_item_t        res_next;

    logic [SET_SIZE_W-1:0] eff_n;
    logic [CHOOSE_W-1:0]   eff_k;
    logic [CHOOSE_W-1:0]   p_in;
    logic [IDX_W-1:0]      cur;
    logic [IDX_W-1:0]      base;
    logic [LIM_W-1:0]      limit;
    logic                  ptr_last;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg     <= SET_SIZE_RST;
            choose_count_reg <= CHOOSE_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_SET_SIZE:     set_size_reg     <= cfg_wdata[SET_SIZE_W-1:0];
                CFG_CHOOSE_COUNT: choose_count_reg <= cfg_wdata[CHOOSE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamped N and k
    always_comb
    begin
        if (set_size_reg == '0)
        begin
            eff_n = SET_SIZE_W'(1);
        end
        else if (int'(set_size_reg) > EFF_MAX)
        begin
            eff_n = SET_SIZE_W'(EFF_MAX);
        end
        else
        begin
            eff_n = set_size_reg;
        end

        if (choose_count_reg == '0)
        begin
            eff_k = CHOOSE_W'(1);
        end
        else if (int'(choose_count_reg) > K_CAP)
        begin
            eff_k = CHOOSE_W'(K_CAP);
        end
        else
        begin
            eff_k = choose_count_reg;
        end
    end

    assign p_in  = CHOOSE_W'(req.prefix_length);
    assign cur   = idx_reg[ptr_reg];
    assign base  = cur + 1'b1;
    // Highest value position ptr may hold: N - k + ptr (k <= N when scanning)
    assign limit = LIM_W'(eff_n) + LIM_W'(ptr_reg) - LIM_W'(eff_k);
    assign ptr_last = (CW'(ptr_reg) + CW'(1)) == CW'(eff_k);

    always_comb
    begin
        idx_next       = idx_reg;
        finished_next  = finished_reg;
        ptr_next       = ptr_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (cmd.restart)
        begin
            for (int j = 0; j < MAX_CHOOSE; j++)
            begin
                idx_next[j] = IDX_W'(j);
            end
            finished_next = (SET_SIZE_W'(eff_k) > eff_n);
        end

        if (cmd.fin_set)
        begin
            finished_next = 1'b1;
        end

        if (cmd.bump)
        begin
            // Bump this position, refill later ones consecutively up to k-1
            for (int j = 0; j < MAX_CHOOSE; j++)
            begin
                if (j == int'(ptr_reg))
                begin
                    idx_next[j] = base;
                end
                else if (j > int'(ptr_reg) && j < int'(eff_k))
                begin
                    idx_next[j] = IDX_W'(int'(base) + j - int'(ptr_reg));
                end
            end
            finished_next = 1'b0;
        end

        if (cmd.scan_start)
        begin
            if (req_reg == REQ_NEXT)
            begin
                ptr_next = PTR_W'(eff_k - 1'b1);
            end
            else
            begin
                ptr_next = PTR_W'(p_eff_reg - 1'b1);
            end
        end
        else if (cmd.ptr_clear)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - 1'b1;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.emit)
        begin
            res_valid_next         = 1'b1;
            res_next.position      = POS_W'(ptr_reg);
            res_next.element_index = ELEM_W'(cur);
            res_next.done_res      = finished_reg;
            res_next.last          = ptr_last;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_CHOOSE; j++)
            begin
                idx_reg[j] <= IDX_W'(j);
            end
            finished_reg  <= 1'b0;
            ptr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            finished_reg  <= finished_next;
            ptr_reg       <= ptr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.accept)
        begin
            req_reg   <= req.req_type;
            p_eff_reg <= (p_in > eff_k) ? eff_k : p_in;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        status.is_restart  = (req_reg == REQ_RESTART);
        status.is_next     = (req_reg == REQ_NEXT);
        status.is_skip     = (req_reg == REQ_SKIP);
        status.k_gt_n      = (SET_SIZE_W'(eff_k) > eff_n);
        status.finished    = finished_reg;
        status.prefix_zero = (p_eff_reg == '0);
        status.can_rise    = (LIM_W'(cur) < limit);
        status.ptr_zero    = (ptr_reg == '0);
        status.ptr_last    = ptr_last;
        status.out_free    = !res_valid_reg || !res_stall;
    end

endmodule

/* sim/combination_enumerator_with_skip_test.sv */
module combination_enumerator_with_skip_test;
    import cep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Block sizing, kept in step with the instance below
    localparam int MAX_CHOOSE   = 8;
    localparam int MAX_SET_SIZE = 1024;

    // Request code the block must treat as a no-op re-emit
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Run shape
    localparam int RANDOM_ITEMS = 345;
    localparam int TAIL_ITEMS   = 60;    // final stretch runs with no idling on either side
    localparam int LONG_HOLD    = 150;   // receiver hold-off, long enough to back the block up
    localparam int DRAIN_CYCLES = 2 * MAX_CHOOSE + 4;  // worst request latency plus margin
    localparam int RUN_LIMIT_NS = 2_000_000;

    localparam logic [CFG_DATA_W-1:0] NO_CFG = '0;

    // Directed script: either a register pair to write while idle, or a request.
    // Rows flagged typed carry their results written out by hand; the rest go
    // through the predictor.
    typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        logic [REQ_W-1:0]                  op;
        logic [PREFIX_W-1:0]               prefix;
        logic [CFG_DATA_W-1:0]             set_n;
        logic [CFG_DATA_W-1:0]             choose_k;
        bit                                typed;
        bit                                exp_done;
        logic [0:MAX_CHOOSE-1][ELEM_W-1:0] exp_idx;
    } script_row_t;

    localparam int NUM_ROWS = 30;

    localparam script_row_t SCRIPT [NUM_ROWS] = '{
        // reset settings: N = 8, k = 2
        '{ROW_REQ, REQ_RESTART, 4'd0, NO_CFG, NO_CFG, 1'b1, 1'b0, '{0:10'd0, 1:10'd1, default:'0}},
        '{ROW_REQ, REQ_NEXT,    4'd0, NO_CFG, NO_CFG, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_SKIP,    4'd1, NO_CFG, NO_CFG, 1'b0, 1'b0, '0},
        // empty prefix drops everything, indices held
        '{ROW_REQ, REQ_SKIP,    4'd0, NO_CFG, NO_CFG, 1'b1, 1'b1, '{0:10'd1, 1:10'd2, default:'0}},
        // requests once exhausted only re-emit
        '{ROW_REQ, REQ_NEXT,    4'd0, NO_CFG, NO_CFG, 1'b1, 1'b1, '{0:10'd1, 1:10'd2, default:'0}},
        '{ROW_REQ, REQ_UNUSED,  4'd0, NO_CFG, NO_CFG, 1'b1, 1'b1, '{0:10'd1, 1:10'd2, default:'0}},
        '{ROW_REQ, REQ_RESTART, 4'd0, NO_CFG, NO_CFG, 1'b1, 1'b0, '{0:10'd0, 1:10'd1, default:'0}},
        // prefix beyond k clamps to k
        '{ROW_REQ, REQ_SKIP,    4'd15, NO_CFG, NO_CFG, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_SKIP,    4'd2, NO_CFG, NO_CFG, 1'b0, 1'b0, '0},
        // k = N: a single combination
        '{ROW_CFG, REQ_RESTART, 4'd0, 11'd3, 11'd3, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_RESTART, 4'd0, NO_CFG, NO_CFG, 1'b1, 1'b0,
          '{0:10'd0, 1:10'd1, 2:10'd2, default:'0}},
        '{ROW_REQ, REQ_NEXT,    4'd0, NO_CFG, NO_CFG, 1'b1, 1'b1,
          '{0:10'd0, 1:10'd1, 2:10'd2, default:'0}},
        '{ROW_REQ, REQ_SKIP,    4'd3, NO_CFG, NO_CFG, 1'b1, 1'b1,
          '{0:10'd0, 1:10'd1, 2:10'd2, default:'0}},
        // more chosen than available
        '{ROW_CFG, REQ_RESTART, 4'd0, 11'd3, 11'd4, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_RESTART, 4'd0, NO_CFG, NO_CFG, 1'b1, 1'b1,
          '{0:10'd0, 1:10'd1, 2:10'd2, 3:10'd3, default:'0}},
        '{ROW_REQ, REQ_NEXT,    4'd0, NO_CFG, NO_CFG, 1'b1, 1'b1,
          '{0:10'd0, 1:10'd1, 2:10'd2, 3:10'd3, default:'0}},
        '{ROW_REQ, REQ_SKIP,    4'd1, NO_CFG, NO_CFG, 1'b1, 1'b1,
          '{0:10'd0, 1:10'd1, 2:10'd2, 3:10'd3, default:'0}},
        // zero registers read as one
        '{ROW_CFG, REQ_RESTART, 4'd0, 11'd0, 11'd0, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_RESTART, 4'd0, NO_CFG, NO_CFG, 1'b1, 1'b0, '{0:10'd0, default:'0}},
        '{ROW_REQ, REQ_NEXT,    4'd0, NO_CFG, NO_CFG, 1'b1, 1'b1, '{0:10'd0, default:'0}},
        // oversized registers clamp to the block maxima
        '{ROW_CFG, REQ_RESTART, 4'd0, 11'd2047, 11'd15, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_RESTART, 4'd0, NO_CFG, NO_CFG, 1'b1, 1'b0,
          '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7}},
        '{ROW_REQ, REQ_SKIP,    4'd8, NO_CFG, NO_CFG, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_NEXT,    4'd0, NO_CFG, NO_CFG, 1'b0, 1'b0, '0},
        // skip carrying out past position zero
        '{ROW_CFG, REQ_RESTART, 4'd0, 11'd4, 11'd2, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_RESTART, 4'd0, NO_CFG, NO_CFG, 1'b1, 1'b0, '{0:10'd0, 1:10'd1, default:'0}},
        '{ROW_REQ, REQ_SKIP,    4'd1, NO_CFG, NO_CFG, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_SKIP,    4'd1, NO_CFG, NO_CFG, 1'b0, 1'b0, '0},
        '{ROW_REQ, REQ_SKIP,    4'd1, NO_CFG, NO_CFG, 1'b1, 1'b1, '{0:10'd2, 1:10'd3, default:'0}},
        '{ROW_REQ, REQ_NEXT,    4'd0, NO_CFG, NO_CFG, 1'b1, 1'b1, '{0:10'd2, 1:10'd3, default:'0}}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  req_valid;
    logic                  req_stall;
    req_item_t             req;
    logic                  res_valid;
    logic                  res_stall;
    res_item_t             res;

    // Predictor copy of the block: registers, current combination, exhausted flag
    logic [SET_SIZE_W-1:0] model_set_size;
    logic [CHOOSE_W-1:0]   model_choose;
    int                    model_combo [MAX_CHOOSE];
    bit                    model_exhausted;

    // Results still owed by the block, oldest first
    res_item_t             pending [$];

    int                    failures;
    bit                    long_hold_pending;  // sender asks, receiver carries it out
    bit                    tail_part;          // no idling from here on
    int                    send_calm;          // sender items left in a no-gap stretch

    combination_enumerator_with_skip #(
        .MAX_CHOOSE   (MAX_CHOOSE),
        .MAX_SET_SIZE (MAX_SET_SIZE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : reset_gen
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // N as the block uses it: zero reads as one, clamped to the block maximum
    function automatic int eff_set_size();
        int n;
        n = int'(model_set_size);
        if (n == 0) n = 1;
        if (n > MAX_SET_SIZE) n = MAX_SET_SIZE;
        return n;
    endfunction

    function automatic int eff_choose();
        int k;
        k = int'(model_choose);
        if (k == 0) k = 1;
        if (k > MAX_CHOOSE) k = MAX_CHOOSE;
        return k;
    endfunction

    // Positions after a bumped one continue consecutively from it
    function automatic void refill_after(int from, int k, int base);
        for (int j = from; j < k; j++)
            model_combo[j] = base + (j - from) + 1;
    endfunction

    // Moves the held combination on by one request transaction
    function automatic void step_combination(req_item_t item);
        int  n;
        int  k;
        int  i;
        int  p;
        int  v;
        bit  moved;
        n = eff_set_size();
        k = eff_choose();
        case (item.req_type)
            REQ_RESTART:
            begin
                foreach (model_combo[j]) model_combo[j] = j;
                model_exhausted = (k > n);
            end
            REQ_NEXT, REQ_SKIP:
            begin
                if (k > n)
                    model_exhausted = 1'b1;
                else if (!model_exhausted)
                begin
                    if (item.req_type == REQ_NEXT)
                    begin
                        // rightmost position still below its ceiling N-k+i;
                        // stale values above it count as unable to rise
                        i = k - 1;
                        while (i >= 0 && model_combo[i] >= n - k + i) i--;
                        if (i < 0)
                            model_exhausted = 1'b1;
                        else
                        begin
                            model_combo[i] = model_combo[i] + 1;
                            refill_after(i + 1, k, model_combo[i]);
                        end
                    end
                    else
                    begin
                        // bump the last prefix position, carrying leftward;
                        // falling off position zero leaves the indices alone
                        p = (int'(item.prefix_length) > k) ? k : int'(item.prefix_length);
                        moved = 1'b0;
                        for (i = p - 1; i >= 0 && !moved; i--)
                        begin
                            v = model_combo[i] + 1;
                            if (v + (k - 1 - i) < n)
                            begin
                                model_combo[i] = v;
                                refill_after(i + 1, k, v);
                                moved = 1'b1;
                            end
                        end
                        model_exhausted = !moved;
                    end
                end
            end
            default: ;  // unused code: nothing changes
        endcase
    endfunction

    // One result transaction per position, final one flagged
    function automatic void queue_results(bit done, logic [0:MAX_CHOOSE-1][ELEM_W-1:0] idx);
        int        k;
        res_item_t r;
        k = eff_choose();
        for (int j = 0; j < k; j++)
        begin
            r.position      = POS_W'(j);
            r.element_index = idx[j];
            r.done_res      = done;
            r.last          = (j == k - 1);
            pending.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- sender

    // Offers one request and holds it until taken, then books its results.
    // Leaves req_valid high so a following request can go back-to-back.
    task automatic issue_request(req_item_t item, bit typed, bit typed_done,
                                 logic [0:MAX_CHOOSE-1][ELEM_W-1:0] typed_idx);
        logic [0:MAX_CHOOSE-1][ELEM_W-1:0] held;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        step_combination(item);
        if (typed)
            queue_results(typed_done, typed_idx);
        else
        begin
            foreach (model_combo[j]) held[j] = ELEM_W'(model_combo[j]);
            queue_results(model_exhausted, held);
        end
    endtask

    // Random gaps between requests, with occasional gap-free stretches
    task automatic sender_gap();
        if (tail_part) return;
        if (send_calm > 0)
        begin
            send_calm--;
            return;
        end
        case ($urandom_range(0, 9))
            0, 1:
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            2: send_calm = $urandom_range(15, 40);
            default: ;
        endcase
    endtask

    // Sender stops and waits out every owed result, then the block's latency
    task automatic wait_for_idle();
        req_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] n_val, logic [CFG_DATA_W-1:0] k_val,
                                bit wr_n, bit wr_k);
        if (wr_n)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_SET_SIZE;
            cfg_wdata <= n_val;
            @(posedge clk);
            model_set_size = n_val;
        end
        if (wr_k)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_CHOOSE_COUNT;
            cfg_wdata <= k_val;
            @(posedge clk);
            model_choose = k_val[CHOOSE_W-1:0];
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : request_side
        req_item_t             item;
        int                    random_sent;
        int                    run_len;
        int                    phase;
        int                    k;
        bit                    wr_n;
        bit                    wr_k;
        logic [CFG_DATA_W-1:0] n_val;
        logic [CFG_DATA_W-1:0] k_val;

        req_valid         = 1'b0;
        req               = '0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_SET_SIZE;
        cfg_wdata         = '0;
        long_hold_pending = 1'b0;
        tail_part         = 1'b0;
        send_calm         = 0;
        failures          = 0;
        model_set_size    = SET_SIZE_RST;
        model_choose      = CHOOSE_COUNT_RST;
        model_exhausted   = 1'b0;
        foreach (model_combo[j]) model_combo[j] = j;
        random_sent       = 0;
        phase             = 0;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed walk through the script
        foreach (SCRIPT[r])
        begin
            if (SCRIPT[r].kind == ROW_CFG)
            begin
                wait_for_idle();
                write_config(SCRIPT[r].set_n, SCRIPT[r].choose_k, 1'b1, 1'b1);
            end
            else
            begin
                item.req_type      = SCRIPT[r].op;
                item.prefix_length = SCRIPT[r].prefix;
                issue_request(item, SCRIPT[r].typed, SCRIPT[r].exp_done, SCRIPT[r].exp_idx);
                sender_gap();
            end
        end

        // Random phases. Each one starts from an idle block (sender pauses until
        // every owed result is in), picks new settings, and mostly restarts
        // before walking the enumeration with next and skip. Phases without a
        // restart, or with only one register rewritten, leave stale indices.
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_for_idle();

            case ($urandom_range(0, 9))
                0:       n_val = '0;
                1:       n_val = {CFG_DATA_W{1'b1}};
                2:       n_val = CFG_DATA_W'($urandom_range(MAX_SET_SIZE - 1, MAX_SET_SIZE + 1));
                3:       n_val = CFG_DATA_W'($urandom_range(13, 2047));
                default: n_val = CFG_DATA_W'($urandom_range(1, 12));
            endcase
            // upper bits of the write data are noise for the narrow register
            k_val = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 9))
                0:       k_val[CHOOSE_W-1:0] = '0;
                1:       k_val[CHOOSE_W-1:0] = CHOOSE_W'($urandom_range(MAX_CHOOSE + 1, 15));
                default: k_val[CHOOSE_W-1:0] = CHOOSE_W'($urandom_range(1, MAX_CHOOSE));
            endcase
            case ($urandom_range(0, 4))
                0:       begin wr_n = 1'b1; wr_k = 1'b0; end
                1:       begin wr_n = 1'b0; wr_k = 1'b1; end
                default: begin wr_n = 1'b1; wr_k = 1'b1; end
            endcase
            write_config(n_val, k_val, wr_n, wr_k);

            // second phase: receiver holds off for a long stretch while
            // requests keep coming, so the block backs up onto its input
            if (phase == 1) long_hold_pending = 1'b1;
            run_len = (phase == 1) ? 40 : $urandom_range(8, 30);

            if ($urandom_range(0, 3) != 0)
            begin
                item.req_type      = REQ_RESTART;
                item.prefix_length = PREFIX_W'($urandom_range(0, 15));
                issue_request(item, 1'b0, 1'b0, '0);
                random_sent++;
                sender_gap();
            end

            for (int i = 0; i < run_len && random_sent < RANDOM_ITEMS; i++)
            begin
                k = eff_choose();
                item.prefix_length = PREFIX_W'($urandom_range(0, 15));
                if (model_exhausted && $urandom_range(0, 2) == 0)
                    item.req_type = REQ_RESTART;
                else
                begin
                    case ($urandom_range(0, 19))
                        0:             item.req_type = REQ_RESTART;
                        1:             item.req_type = REQ_UNUSED;
                        2, 3, 4, 5, 6:
                        begin
                            item.req_type      = REQ_SKIP;
                            item.prefix_length = PREFIX_W'($urandom_range(0, k));
                        end
                        7:             item.req_type = REQ_SKIP;  // prefix over its whole range
                        default:       item.req_type = REQ_NEXT;
                    endcase
                end
                issue_request(item, 1'b0, 1'b0, '0);
                random_sent++;
                tail_part = (random_sent >= RANDOM_ITEMS - TAIL_ITEMS);
                sender_gap();
            end
            phase++;
        end

        wait_for_idle();
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    // Random stall bursts, calm stretches, one long hold-off
    initial
    begin : result_side
        int hold_left;
        int calm_left;
        hold_left = 0;
        calm_left = 0;
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                hold_left         = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (tail_part || calm_left > 0)
            begin
                if (calm_left > 0) calm_left--;
                res_stall <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0, 1, 2:
                    begin
                        hold_left = $urandom_range(0, 4);
                        res_stall <= 1'b1;
                    end
                    3:
                    begin
                        calm_left = $urandom_range(20, 60);
                        res_stall <= 1'b0;
                    end
                    default: res_stall <= 1'b0;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- checker

    task automatic flag_mismatch(string what, int want_v, int got_v);
        failures++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    endtask

    // Every result transaction taken is matched against the oldest owed one
    always @(posedge clk)
    begin : result_check
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending.size() == 0)
            begin
                failures++;
                $display("%0t ns: result transaction with none expected, actual pos %0d idx %0d",
                         $time, res.position, res.element_index);
            end
            else
            begin
                want = pending.pop_front();
                if (res.position !== want.position)
                    flag_mismatch("position", want.position, res.position);
                if (res.element_index !== want.element_index)
                    flag_mismatch("element_index", want.element_index, res.element_index);
                if (res.done_res !== want.done_res)
                    flag_mismatch("done_res", want.done_res, res.done_res);
                if (res.last !== want.last)
                    flag_mismatch("last", want.last, res.last);
            end
        end
    end

endmodule
